// ===== rtl/ids_pkg.sv =====
package ids_pkg;

   // result codes
   typedef enum logic [2:0] {
      EV_PAYLOAD    = 3'd0,
      EV_HDR_OK     = 3'd1,
      EV_HDR_REJECT = 3'd2,
      EV_PADDING    = 3'd3,
      EV_BAD_SIZE   = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_HEADER    = 3'd1,
      PH_FRAME_HDR = 3'd2,
      PH_PAYLOAD   = 3'd3,
      PH_STOPPED   = 3'd4
   } phase_type;

   localparam logic [7:0]  MAGIC_0        = 8'h49;
   localparam logic [7:0]  MAGIC_1        = 8'h44;
   localparam logic [7:0]  MAGIC_2        = 8'h33;
   localparam logic [7:0]  TAG_VERSION    = 8'h02;
   localparam int          UNSYNC_BIT     = 6;
   localparam logic [3:0]  HDR_VER_IDX    = 4'd3;
   localparam logic [3:0]  HDR_FLAGS_IDX  = 4'd5;
   localparam logic [3:0]  HDR_SIZE_IDX   = 4'd6;
   localparam logic [3:0]  HDR_LAST_IDX   = 4'd9;
   localparam logic [3:0]  FRM_SIZE_IDX   = 4'd3;
   localparam logic [3:0]  FRM_LAST_IDX   = 4'd5;
   localparam logic [27:0] MIN_FRAME_BYTES = 28'd6;
   localparam logic [4:0]  KIND_UNKNOWN   = 5'd16;
   localparam int          NUM_KEYS       = 16;
   localparam int          QUEUE_DEPTH    = 2;

   localparam logic [23:0] KNOWN_KEYS [NUM_KEYS] = '{
      24'h54414C, // TAL
      24'h545432, // TT2
      24'h54434D, // TCM
      24'h544352, // TCR
      24'h544441, // TDA
      24'h544C45, // TLE
      24'h545031, // TP1
      24'h545032, // TP2
      24'h54524B, // TRK
      24'h545945, // TYE
      24'h54434F, // TCO
      24'h434F4D, // COM
      24'h545353, // TSS
      24'h545858, // TXX
      24'h525641, // RVA
      24'h504943  // PIC
   };

   typedef struct packed {
      event_type   event_res;
      logic [7:0]  payload_byte;
      logic [4:0]  frame_kind;
      logic        frame_first;
      logic        frame_last;
      logic        tag_last;
      logic [27:0] tag_size;
      logic        unsync_flag;
   } ids_rsp_type;

   typedef struct packed {
      logic        valid;
      ids_rsp_type data;
   } queue_push_type;

   typedef struct packed {
      logic full;
   } queue_status_type;

   function automatic logic [4:0] classify_key(input logic [23:0] key);
      logic [4:0] kind;
      kind = KIND_UNKNOWN;
      for (int i = NUM_KEYS - 1; i >= 0; i--) begin
         if (KNOWN_KEYS[i] == key) kind = 5'(i);
      end
      return kind;
   endfunction

endpackage

// ===== rtl/ids_if.sv =====
interface ids_req_if;
   import ids_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] tag_byte;
   logic       start_of_tag;

   modport source (output valid, output tag_byte, output start_of_tag, input ready);
   modport sink (input valid, input tag_byte, input start_of_tag, output ready);
endinterface

interface ids_rsp_if;
   import ids_pkg::*;
   logic        valid;
   logic        ready;
   event_type   event_res;
   logic [7:0]  payload_byte;
   logic [4:0]  frame_kind;
   logic        frame_first;
   logic        frame_last;
   logic        tag_last;
   logic [27:0] tag_size;
   logic        unsync_flag;

   modport source (output valid, output event_res, output payload_byte, output frame_kind,
                   output frame_first, output frame_last, output tag_last, output tag_size,
                   output unsync_flag, input ready);
   modport sink (input valid, input event_res, input payload_byte, input frame_kind,
                 input frame_first, input frame_last, input tag_last, input tag_size,
                 input unsync_flag, output ready);
endinterface

// ===== rtl/ids_front.sv =====
module ids_front (
   input  logic                      clock,
   input  logic                      reset,
   ids_req_if.sink                   req_ch,
   input  ids_pkg::queue_status_type q_status,
   output ids_pkg::queue_push_type   q_push
);
   import ids_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic        magic_ff, magic_in;
   logic [7:0]  flags_ff, flags_in;
   logic [27:0] left_ff, left_in;
   logic [23:0] key_ff, key_in;
   logic [27:0] size_ff, size_in;
   logic [23:0] pleft_ff, pleft_in;
   logic [4:0]  kind_ff, kind_in;

   logic        accept;
   logic [3:0]  idx;
   logic [7:0]  b;
   logic        is_last;

   assign req_ch.ready = !q_status.full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign b            = req_ch.tag_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         magic_ff <= 1'b1;
         flags_ff <= '0;
         left_ff  <= '0;
         key_ff   <= '0;
         size_ff  <= '0;
         pleft_ff <= '0;
         kind_ff  <= KIND_UNKNOWN;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         magic_ff <= magic_in;
         flags_ff <= flags_in;
         left_ff  <= left_in;
         key_ff   <= key_in;
         size_ff  <= size_in;
         pleft_ff <= pleft_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      magic_in = magic_ff;
      flags_in = flags_ff;
      left_in  = left_ff;
      key_in   = key_ff;
      size_in  = size_ff;
      pleft_in = pleft_ff;
      kind_in  = kind_ff;
      idx      = '0;
      is_last  = 1'b0;
      q_push   = '0;
      if (accept) begin
         // a start flag restarts header parsing on this very byte
         if (req_ch.start_of_tag) begin
            phase_in = PH_HEADER;
            count_in = '0;
            magic_in = 1'b1;
            flags_in = '0;
            size_in  = '0;
         end
         idx = count_in;
         case (phase_in)
            PH_HEADER: begin
               if (idx == 4'd0 && b != MAGIC_0) magic_in = 1'b0;
               if (idx == 4'd1 && b != MAGIC_1) magic_in = 1'b0;
               if (idx == 4'd2 && b != MAGIC_2) magic_in = 1'b0;
               if (idx == HDR_VER_IDX && b != TAG_VERSION) magic_in = 1'b0;
               if (idx == HDR_FLAGS_IDX) flags_in = b;
               // syncsafe: seven bits per byte
               if (idx >= HDR_SIZE_IDX) size_in = {size_in[20:0], b[6:0]};
               count_in = count_in + 4'd1;
               if (idx == HDR_LAST_IDX) begin
                  q_push.valid = 1'b1;
                  if (!magic_in) begin
                     phase_in = PH_STOPPED;
                     q_push.data.event_res = EV_HDR_REJECT;
                  end else begin
                     left_in = size_in;
                     q_push.data.event_res   = EV_HDR_OK;
                     q_push.data.tag_size    = size_in;
                     q_push.data.unsync_flag = flags_in[UNSYNC_BIT];
                     count_in = '0;
                     phase_in = (size_in < MIN_FRAME_BYTES) ? PH_STOPPED : PH_FRAME_HDR;
                  end
               end
            end
            PH_FRAME_HDR: begin
               if (idx < FRM_SIZE_IDX) key_in = {key_in[15:0], b};
               else if (idx == FRM_SIZE_IDX) size_in = {20'd0, b};
               else size_in = {4'd0, size_in[15:0], b};
               count_in = count_in + 4'd1;
               if (idx == FRM_LAST_IDX) begin
                  left_in = left_in - MIN_FRAME_BYTES;
                  if (key_in[23:16] == 8'd0) begin
                     phase_in = PH_STOPPED;
                     q_push.valid = 1'b1;
                     q_push.data.event_res = EV_PADDING;
                  end else if (size_in == '0 || size_in > left_in) begin
                     phase_in = PH_STOPPED;
                     q_push.valid = 1'b1;
                     q_push.data.event_res = EV_BAD_SIZE;
                  end else begin
                     kind_in  = classify_key(key_in);
                     pleft_in = size_in[23:0];
                     count_in = '0;
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               is_last  = pleft_in <= 24'd1;
               q_push.valid = 1'b1;
               q_push.data.event_res    = EV_PAYLOAD;
               q_push.data.payload_byte = b;
               q_push.data.frame_kind   = kind_in;
               q_push.data.frame_first  = count_in == 4'd0;
               q_push.data.frame_last   = is_last;
               count_in = 4'd1;
               pleft_in = pleft_in - 24'd1;
               left_in  = left_in - 28'd1;
               if (is_last) begin
                  q_push.data.tag_last = left_in < MIN_FRAME_BYTES;
                  count_in = '0;
                  phase_in = (left_in < MIN_FRAME_BYTES) ? PH_STOPPED : PH_FRAME_HDR;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== rtl/ids_back.sv =====
module ids_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ids_pkg::queue_push_type   q_push,
   output ids_pkg::queue_status_type q_status,
   ids_rsp_if.source                 rsp_ch
);
   import ids_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ids_rsp_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop;
   ids_rsp_type        head;

   assign pop             = rsp_ch.valid && rsp_ch.ready;
   assign q_status.full   = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head            = slot_ff[rd_ptr_ff];

   assign rsp_ch.valid        = count_ff != '0;
   assign rsp_ch.event_res    = head.event_res;
   assign rsp_ch.payload_byte = head.payload_byte;
   assign rsp_ch.frame_kind   = head.frame_kind;
   assign rsp_ch.frame_first  = head.frame_first;
   assign rsp_ch.frame_last   = head.frame_last;
   assign rsp_ch.tag_last     = head.tag_last;
   assign rsp_ch.tag_size     = head.tag_size;
   assign rsp_ch.unsync_flag  = head.unsync_flag;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (q_push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (q_push.valid && !pop) count_in = count_ff + CNT_W'(1);
      else if (!q_push.valid && pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.valid) slot_ff[wr_ptr_ff] <= q_push.data;
   end

endmodule

// ===== rtl/id3v22_frame_splitter.sv =====
// ID3v2.2 tag splitter
// req_ch carries the raw tag stream, one byte per transfer, with start_of_tag
// high on the first header byte. rsp_ch carries at most one result per byte:
// header accepted (with syncsafe size and the 0x40 flag), header rejected,
// padding stop, bad frame size, or a frame payload byte tagged with its frame
// kind and first/last/tag-end marks.
// Throughput: one byte per cycle while the queue is not full. The parser
// decides each byte in the cycle of its transfer and writes any result into
// a two-entry queue; the result is offered on rsp_ch from the next cycle on.
// When rsp_ch stalls, the queue absorbs up to two results; req_ch.ready drops
// only while the queue is full and comes back the cycle after a result leaves.
// Bytes that give no result (header, frame header, stopped) still need a free
// queue slot to be taken.
// Reset: parser idle, ignoring bytes until a start flag; queue empty.
module id3v22_frame_splitter (
   input  logic       clock,
   input  logic       reset,
   ids_req_if.sink    req_ch,
   ids_rsp_if.source  rsp_ch
);
   import ids_pkg::*;

   queue_push_type   q_push;
   queue_status_type q_status;

   ids_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_status (q_status),
      .q_push   (q_push)
   );

   ids_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_status (q_status),
      .rsp_ch   (rsp_ch)
   );

   // tag end can only fall on the last byte of a frame
   a_tag_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.tag_last |-> rsp_ch.frame_last && rsp_ch.event_res == EV_PAYLOAD)
      else $error("tag_last without frame_last");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.event_res != EV_PAYLOAD
         |-> rsp_ch.payload_byte == 8'd0 && rsp_ch.frame_kind == 5'd0 && !rsp_ch.frame_first)
      else $error("status result carries payload fields");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push.valid |-> !q_status.full)
      else $error("queue written while full");

   // the first header byte never produces a result
   a_start_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && req_ch.start_of_tag |-> !q_push.valid)
      else $error("result on start byte");

endmodule
